[rtl/core/gbnms_pkg.sv]
package gbnms_pkg;

    localparam int MAX_KEPT  = 256;
    localparam int MAX_BOXES = 4096;
    localparam int KEPT_W    = $clog2(MAX_KEPT);
    localparam int COUNT_W   = $clog2(MAX_KEPT + 1);
    localparam int INDEX_CAP = (MAX_BOXES - 1 < 4095) ? MAX_BOXES - 1 : 4095;

    localparam logic REG_IOU_THRESHOLD  = 1'b0;
    localparam logic REG_CLASS_AGNOSTIC = 1'b1;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        w;
        logic [15:0]        h;
        logic [7:0]         cls;
        logic [31:0]        area;
        logic               last;
        logic [11:0]        index;
    } box_t;

endpackage

[rtl/core/gbnms_front.sv]
module gbnms_front
    import gbnms_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] box_x,
    input  logic signed [15:0] box_y,
    input  logic [15:0]        box_width,
    input  logic [15:0]        box_height,
    input  logic [7:0]         class_label,
    input  logic               last_box,
    output logic               q_valid,
    input  logic               q_ready,
    output box_t               q_data
);

    localparam int Q_DEPTH = 2;

    // stage: index and area
    logic        s_valid_reg;
    box_t        s_data_reg;
    logic [11:0] counter_reg;
    logic [11:0] counter_next;

    box_t        fifo_reg [Q_DEPTH];
    logic [1:0]  fill_reg;
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic        push;
    logic        pop;
    logic        s_move;

    assign push     = s_valid_reg && (fill_reg != 2'(Q_DEPTH));
    assign pop      = q_valid && q_ready;
    assign s_move   = !s_valid_reg || push;
    assign in_ready = s_move;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_data   = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        counter_next = counter_reg;
        if (in_valid && in_ready)
        begin
            if (last_box)
                counter_next = 12'd0;
            else if (counter_reg < 12'(INDEX_CAP))
                counter_next = counter_reg + 12'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            counter_reg <= 12'd0;
            fill_reg    <= 2'd0;
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
        end
        else
        begin
            counter_reg <= counter_next;
            if (s_move)
                s_valid_reg <= in_valid;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_move && in_valid)
        begin
            s_data_reg.x     <= box_x;
            s_data_reg.y     <= box_y;
            s_data_reg.w     <= box_width;
            s_data_reg.h     <= box_height;
            s_data_reg.cls   <= class_label;
            s_data_reg.area  <= box_width * box_height;
            s_data_reg.last  <= last_box;
            s_data_reg.index <= counter_reg;
        end
        if (push)
            fifo_reg[wr_ptr_reg] <= s_data_reg;
    end

endmodule

[rtl/core/gbnms_back.sv]
module gbnms_back
    import gbnms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] iou_threshold,
    input  logic        class_agnostic,
    input  logic        q_valid,
    output logic        q_ready,
    input  box_t        q_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        keep,
    output logic [11:0] box_index,
    output logic        kept_full,
    output logic        last_result
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_OVL   = 3'd2;
    localparam logic [2:0] ST_INTER = 3'd3;
    localparam logic [2:0] ST_CMP   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam int ENTRY_W = 16 * 4 + 8 + 32;

    logic [ENTRY_W-1:0]  mem [MAX_KEPT];
    logic [ENTRY_W-1:0]  rd_reg;

    logic [2:0]          state_reg;
    box_t                cur_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  j_reg;
    logic                keep_reg;
    logic                cmp_en_reg;
    logic [16:0]         ox_reg;
    logic [16:0]         oy_reg;
    logic [33:0]         inter_reg;
    logic [32:0]         kp_area_reg;

    logic                out_valid_reg;
    logic                o_keep_reg;
    logic [11:0]         o_index_reg;
    logic                o_full_reg;
    logic                o_last_reg;

    logic signed [15:0]  k_x;
    logic signed [15:0]  k_y;
    logic [15:0]         k_w;
    logic [15:0]         k_h;
    logic [7:0]          k_cls;
    logic [31:0]         k_area;

    logic signed [17:0]  a1x, b1x, lox, hix, a1y, b1y, loy, hiy;
    logic [33:0]         uni;
    logic [49:0]         lhs;
    logic [49:0]         rhs;
    logic                store;

    assign {k_x, k_y, k_w, k_h, k_cls, k_area} = rd_reg;

    always_comb
    begin
        a1x = 18'(cur_reg.x) + 18'($signed({1'b0, cur_reg.w}));
        b1x = 18'(k_x) + 18'($signed({1'b0, k_w}));
        lox = (cur_reg.x > k_x) ? 18'(cur_reg.x) : 18'(k_x);
        hix = (a1x < b1x) ? a1x : b1x;
        a1y = 18'(cur_reg.y) + 18'($signed({1'b0, cur_reg.h}));
        b1y = 18'(k_y) + 18'($signed({1'b0, k_h}));
        loy = (cur_reg.y > k_y) ? 18'(cur_reg.y) : 18'(k_y);
        hiy = (a1y < b1y) ? a1y : b1y;
        uni = 34'(cur_reg.area) + 34'(kp_area_reg) - inter_reg;
        lhs = {inter_reg, 16'd0};
        rhs = 50'(uni) * 50'(iou_threshold);
    end

    assign q_ready     = (state_reg == ST_IDLE);
    assign store       = keep_reg && (count_reg < COUNT_W'(MAX_KEPT));
    assign out_valid   = out_valid_reg;
    assign keep        = o_keep_reg;
    assign box_index   = o_index_reg;
    assign kept_full   = o_full_reg;
    assign last_result = o_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            j_reg         <= '0;
            keep_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_DONE && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        j_reg     <= '0;
                        keep_reg  <= 1'b1;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    if (j_reg == count_reg)
                        state_reg <= ST_DONE;
                    else
                        state_reg <= ST_OVL;
                end
                ST_OVL:
                    state_reg <= ST_INTER;
                ST_INTER:
                    state_reg <= ST_CMP;
                ST_CMP:
                begin
                    if (cmp_en_reg && (uni != 34'd0) && (lhs > rhs))
                        keep_reg <= 1'b0;
                    j_reg     <= j_reg + 1'b1;
                    state_reg <= ST_READ;
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        if (cur_reg.last)
                            count_reg <= '0;
                        else if (store)
                            count_reg <= count_reg + 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid)
            cur_reg <= q_data;
        rd_reg <= mem[j_reg[KEPT_W-1:0]];
        if (state_reg == ST_OVL)
        begin
            ox_reg      <= (hix > lox) ? 17'(hix - lox) : 17'd0;
            oy_reg      <= (hiy > loy) ? 17'(hiy - loy) : 17'd0;
            kp_area_reg <= {1'b0, k_area};
            cmp_en_reg  <= class_agnostic || (k_cls == cur_reg.cls);
        end
        if (state_reg == ST_INTER)
            inter_reg <= ox_reg * oy_reg;
        if (state_reg == ST_DONE && (!out_valid_reg || out_ready))
        begin
            if (store)
                mem[count_reg[KEPT_W-1:0]] <= {cur_reg.x, cur_reg.y, cur_reg.w,
                                               cur_reg.h, cur_reg.cls, cur_reg.area};
            o_keep_reg  <= keep_reg;
            o_index_reg <= cur_reg.index;
            o_full_reg  <= keep_reg && !store;
            o_last_reg  <= cur_reg.last;
        end
    end

endmodule

[rtl/core/greedy_box_nms.sv]
// Channel  Dir  Handshake            Payload
// in       in   in_valid/in_ready    box_x box_y box_width box_height class_label last_box
// out      out  out_valid/out_ready  keep box_index kept_full last_result
// cfg      in   cfg_we               cfg_index cfg_data
//
// The back end takes one item at a time and compares it with each kept box of the list (up to 256).
// The rate is set by the single compare unit stepping through the kept-box memory.
// Reset clears counts, pointers and state and loads the default threshold; the kept-box memory needs no clearing.
// A two-entry queue lets the front accept while the back end works or stalls.
module greedy_box_nms
    import gbnms_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] box_x,
    input  logic signed [15:0] box_y,
    input  logic [15:0]        box_width,
    input  logic [15:0]        box_height,
    input  logic [7:0]         class_label,
    input  logic               last_box,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               keep,
    output logic [11:0]        box_index,
    output logic               kept_full,
    output logic               last_result
);

    logic [15:0] iou_threshold_reg;
    logic        class_agnostic_reg;
    logic        q_valid;
    logic        q_ready;
    box_t        q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iou_threshold_reg  <= 16'd29491;
            class_agnostic_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IOU_THRESHOLD:  iou_threshold_reg  <= cfg_data;
                REG_CLASS_AGNOSTIC: class_agnostic_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    gbnms_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .box_x       (box_x),
        .box_y       (box_y),
        .box_width   (box_width),
        .box_height  (box_height),
        .class_label (class_label),
        .last_box    (last_box),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_data      (q_data)
    );

    gbnms_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .iou_threshold  (iou_threshold_reg),
        .class_agnostic (class_agnostic_reg),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_data         (q_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .keep           (keep),
        .box_index      (box_index),
        .kept_full      (kept_full),
        .last_result    (last_result)
    );

    a_full_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kept_full |-> keep)
        else $error("full flag on suppressed box");

    a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && $past(out_valid === 1'b0 && last_result && rst_n, 2)
        |-> box_index == 12'd0)
        else $error("index not restarted");

endmodule

[bench/nms_checker.sv]
`timescale 1ns / 1ps

module nms_checker
    import gbnms_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [15:0] box_x,
    input  logic signed [15:0] box_y,
    input  logic [15:0]        box_width,
    input  logic [15:0]        box_height,
    input  logic [7:0]         class_label,
    input  logic               last_box,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               keep,
    input  logic [11:0]        box_index,
    input  logic               kept_full,
    input  logic               last_result,
    output int                 fail_count,
    output int                 pending,
    output int                 kept_total,
    output int                 full_total
);

    typedef struct packed {
        logic        keep;
        logic [11:0] index;
        logic        full;
        logic        last;
    } verdict_t;

    logic [15:0]        thresh;
    logic               agnostic;
    logic signed [15:0] s_left  [MAX_KEPT];
    logic signed [15:0] s_top   [MAX_KEPT];
    logic [15:0]        s_wide  [MAX_KEPT];
    logic [15:0]        s_tall  [MAX_KEPT];
    logic [7:0]         s_class [MAX_KEPT];
    logic [31:0]        s_area  [MAX_KEPT];
    int                 stored;
    int                 next_index;
    verdict_t           verdicts[$];

    function automatic longint span(longint a0, longint alen, longint b0, longint blen);
        longint lo;
        longint hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = (a0 + alen < b0 + blen) ? a0 + alen : b0 + blen;
        return (hi > lo) ? hi - lo : 0;
    endfunction

    function automatic verdict_t suppress_box(logic signed [15:0] x, logic signed [15:0] y,
                                             logic [15:0] w, logic [15:0] h,
                                             logic [7:0] c, logic lst);
        verdict_t v;
        longint   area;
        longint   inter;
        longint   uni;
        area = longint'(w) * longint'(h);
        v.keep = 1'b1;
        v.full = 1'b0;
        v.last = lst;
        v.index = next_index[11:0];
        for (int j = 0; j < stored; j++) begin
            if (!agnostic && s_class[j] != c)
                continue;
            inter = span(x, w, s_left[j], s_wide[j]) * span(y, h, s_top[j], s_tall[j]);
            uni = area + longint'(s_area[j]) - inter;
            if (uni == 0)
                continue;
            if ((inter << 16) > longint'(thresh) * uni)
                v.keep = 1'b0;
        end
        if (v.keep) begin
            if (stored < MAX_KEPT) begin
                s_left[stored] = x;
                s_top[stored] = y;
                s_wide[stored] = w;
                s_tall[stored] = h;
                s_class[stored] = c;
                s_area[stored] = area[31:0];
                stored++;
            end else begin
                v.full = 1'b1;
            end
        end
        if (next_index < INDEX_CAP)
            next_index++;
        if (lst) begin
            stored = 0;
            next_index = 0;
        end
        return v;
    endfunction

    assign pending = verdicts.size();

    always @(posedge clk or negedge rst_n) begin
        verdict_t v;
        verdict_t got;
        if (!rst_n) begin
            thresh <= 16'd29491;
            agnostic <= 1'b0;
            stored = 0;
            next_index = 0;
            verdicts.delete();
            fail_count <= 0;
            kept_total <= 0;
            full_total <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_IOU_THRESHOLD)
                    thresh <= cfg_data;
                else
                    agnostic <= cfg_data[0];
            end
            if (in_valid && in_ready)
                verdicts.insert(verdicts.size(),
                                suppress_box(box_x, box_y, box_width, box_height,
                                             class_label, last_box));
            if (out_valid && out_ready) begin
                got = '{keep, box_index, kept_full, last_result};
                if (verdicts.size() == 0) begin
                    $display("%0t: unexpected result, actual %p", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    v = verdicts.pop_front();
                    if (v != got) begin
                        $display("%0t: result mismatch, expected %p, actual %p",
                                 $time, v, got);
                        fail_count <= fail_count + 1;
                    end
                    kept_total <= kept_total + v.keep;
                    full_total <= full_total + v.full;
                end
            end
        end
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import gbnms_pkg::*;

    localparam int STALL_LIMIT = 200000;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic [15:0]        box_width;
    logic [15:0]        box_height;
    logic [7:0]         class_label;
    logic               last_box;
    logic               out_valid;
    logic               out_ready;
    logic               keep;
    logic [11:0]        box_index;
    logic               kept_full;
    logic               last_result;
    int                 fail_count;
    int                 pending;
    int                 kept_total;
    int                 full_total;
    int                 idle_cycles;
    int                 box_total;
    bit                 rx_hold;

    greedy_box_nms DUT (.*);

    nms_checker checker_inst (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 120);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
    endfunction

    // hold timeout
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("greedy_box_nms: mismatch");
            $finish;
        end
    end

    initial
    begin
        int g;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                g = gap_len();
                out_ready <= (g == 0);
                repeat (g == 0 ? $urandom_range(1, 30) : g) @(posedge clk);
            end
        end
    end

    task automatic send_box(logic signed [15:0] x, logic signed [15:0] y, logic [15:0] w,
                            logic [15:0] h, logic [7:0] c, logic lst);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        box_x <= x;
        box_y <= y;
        box_width <= w;
        box_height <= h;
        class_label <= c;
        last_box <= lst;
        do @(posedge clk); while (!in_ready);
        box_total++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (1100) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // random list: clustered boxes with random content, some noise
    task automatic send_list(int n, int span_max);
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        cx = 16'($urandom);
        cy = 16'($urandom);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         8'($urandom), (i == n - 1));
            else
                send_box(cx + $signed(16'($urandom_range(0, 64))) - 16'sd32,
                         cy + $signed(16'($urandom_range(0, 64))) - 16'sd32,
                         16'($urandom_range(0, span_max)),
                         16'($urandom_range(0, span_max)),
                         8'($urandom_range(0, 3)), (i == n - 1));
        end
    endtask

    initial
    begin
        cfg_we = 1'b0;
        cfg_index = REG_IOU_THRESHOLD;
        cfg_data = '0;
        in_valid = 1'b0;
        box_x = '0;
        box_y = '0;
        box_width = '0;
        box_height = '0;
        class_label = '0;
        last_box = 1'b0;
        rx_hold = 1'b0;
        box_total = 0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, zero union, empty overlap, class split, last
        send_box(16'sh8000, 16'sh8000, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
        send_box(16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
        send_box(16'sh8000, 16'sh8000, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
        send_box(16'sh8000, 16'sh8000, 16'hFFFF, 16'hFFFF, 8'h00, 1'b0);
        send_box(16'sd0, 16'sd0, 16'd0, 16'd0, 8'd1, 1'b0);
        send_box(16'sd0, 16'sd0, 16'd0, 16'd0, 8'd1, 1'b0);
        send_box(16'sd100, 16'sd100, 16'd50, 16'd50, 8'd2, 1'b0);
        send_box(16'sd150, 16'sd100, 16'd50, 16'd50, 8'd2, 1'b0);
        send_box(16'sd105, 16'sd100, 16'd50, 16'd50, 8'd2, 1'b0);
        send_box(16'sd105, 16'sd100, 16'd50, 16'd50, 8'd3, 1'b1);
        drain();
        write_reg(REG_CLASS_AGNOSTIC, 16'd1);
        write_reg(REG_IOU_THRESHOLD, 16'd0);
        send_box(16'sd10, 16'sd10, 16'd20, 16'd20, 8'd5, 1'b0);
        send_box(16'sd29, 16'sd29, 16'd20, 16'd20, 8'd6, 1'b0);
        send_box(16'sd40, 16'sd40, 16'd20, 16'd20, 8'd7, 1'b1);
        drain();
        write_reg(REG_IOU_THRESHOLD, 16'hFFFF);
        send_box(16'sd10, 16'sd10, 16'd20, 16'd20, 8'd5, 1'b0);
        send_box(16'sd10, 16'sd10, 16'd20, 16'd20, 8'd5, 1'b1);
        drain();

        // store overflow: 262 disjoint boxes, index keeps counting
        write_reg(REG_IOU_THRESHOLD, 16'd0);
        for (int i = 0; i < 262; i++)
            send_box(16'(i * 64) - 16'sd16000, 16'sd0, 16'd32, 16'd32, 8'd9, i == 261);
        rx_hold = 1'b1;
        drain();
        rx_hold = 1'b0;

        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(REG_CLASS_AGNOSTIC, 16'($urandom_range(0, 1)));
            case (phase)
                0: write_reg(REG_IOU_THRESHOLD, 16'd0);
                1: write_reg(REG_IOU_THRESHOLD, 16'hFFFF);
                default: write_reg(REG_IOU_THRESHOLD, 16'($urandom));
            endcase
            for (int l = 0; l < 10; l++)
                send_list($urandom_range(1, 24), (l % 3 == 0) ? 65535 : 96);
            drain();
        end

        $display("boxes: %0d, kept: %0d, kept with full store: %0d",
                 box_total, kept_total, full_total);
        $display("covered threshold extremes, both class modes, store overflow, random lists");
        if (fail_count == 0)
            $display("greedy_box_nms: match");
        else
            $display("greedy_box_nms: mismatch");
        $finish;
    end

endmodule
